[src/rrif_pkg.sv]
// Shared types and fixed widths for the RR-interval feature extractor.
package rrif_pkg;

    localparam int POS_W  = 32;
    localparam int IVL_W  = 16;
    localparam int CNT_W  = 24;
    localparam int MEAN_W = 24;
    localparam int GSUM_W = 40;

    localparam logic [IVL_W-1:0]  IVL_MAX  = {IVL_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [GSUM_W-1:0] GSUM_MAX = {GSUM_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

    typedef struct packed {
        logic [POS_W-1:0] peak_pos;
        logic             final_peak;
    } peak_t;

    typedef struct packed {
        logic [CNT_W-1:0]  beat_index;
        logic [IVL_W-1:0]  pre_interval;
        logic [IVL_W-1:0]  post_interval;
        logic [MEAN_W-1:0] local_mean;
        logic [MEAN_W-1:0] global_mean;
        logic              last_beat;
    } feat_t;

endpackage

[src/rrif_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rrif_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/rrif_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, saturated quotient.
module rrif_div #(
    parameter int NUM_W = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_W-1:0]              num,
    input  logic [rrif_pkg::CNT_W-1:0]    den,
    output logic                          done,
    output logic [rrif_pkg::MEAN_W-1:0]   quot
);

    localparam int DEN_W = rrif_pkg::CNT_W;
    localparam int Q_W   = rrif_pkg::MEAN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   quot_reg;
    logic             ovf_reg;
    logic             zero_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            zero_reg <= (den == '0);
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quot_reg <= {quot_reg[Q_W-2:0], ge};
            ovf_reg  <= ovf_reg | quot_reg[Q_W-1];
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : (ovf_reg ? rrif_pkg::MEAN_MAX : quot_reg);

endmodule

[src/rr_interval_features_top.sv]
// Top level of the RR-interval feature extractor: sequencer, window and mean dividers.
//
//  channel | ports                      | beat carries
//  --------+----------------------------+----------------------------------------
//  peak    | peak_valid peak_stall peak | one R-peak position and final flag
//  feat    | feat_valid feat_stall feat | one feature record for one heartbeat
//
// A peak is taken only while the sequencer is idle. The first peak of a stream
// gives no record. Every other peak yields a record once the bit-serial local
// and global-mean dividers have both finished; a final peak runs the sequence
// twice for two records. The record leaves through a one-deep output register,
// so a new peak can be taken while the last record is stalled; a second record
// waits for it. Reset clears all control state at once; the window RAM needs no
// clearing pass since the fill count keeps unwritten entries from being read.
module rr_interval_features_top #(
    parameter int LOCAL_WINDOW = 10,
    parameter int FRAC_BITS    = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            peak_valid,
    output logic            peak_stall,
    input  rrif_pkg::peak_t peak,
    output logic            feat_valid,
    input  logic            feat_stall,
    output rrif_pkg::feat_t feat
);

    localparam int IVL_W  = rrif_pkg::IVL_W;
    localparam int CNT_W  = rrif_pkg::CNT_W;
    localparam int POS_W  = rrif_pkg::POS_W;
    localparam int GSUM_W = rrif_pkg::GSUM_W;
    localparam int FILL_W = $clog2(LOCAL_WINDOW + 1);
    localparam int HEAD_W = (LOCAL_WINDOW > 1) ? $clog2(LOCAL_WINDOW) : 1;
    localparam int WSUM_W = IVL_W + FILL_W;
    localparam int LNUM_W = WSUM_W + FRAC_BITS;
    localparam int GNUM_W = GSUM_W + FRAC_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]        state_reg, state_next;

    // stream state
    logic [POS_W-1:0]  prev_pos_reg;
    logic [IVL_W-1:0]  pending_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [GSUM_W-1:0] gsum_reg;
    logic [CNT_W-1:0]  count_reg;

    // record under work
    logic [CNT_W-1:0]  rec_idx_reg;
    logic [IVL_W-1:0]  rec_pre_reg;
    logic [IVL_W-1:0]  rec_post_reg;
    logic              rec_last_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              fin_reg;

    rrif_pkg::feat_t   out_reg;
    logic              out_valid_reg;

    logic              peak_acc;
    logic              out_free;
    logic              emit;
    logic [POS_W-1:0]  diff;
    logic [IVL_W-1:0]  gap;
    logic [IVL_W-1:0]  ring_rdata;
    logic [WSUM_W-1:0] wsum_new;
    logic [FILL_W-1:0] fill_new;
    logic              win_full;
    logic [GSUM_W:0]   gsum_add;
    logic [LNUM_W-1:0] loc_num;
    logic [CNT_W-1:0]  loc_den;
    logic [GNUM_W-1:0] glob_num;
    logic [CNT_W-1:0]  glob_den;
    logic              div_start;
    logic              loc_done, glob_done;
    logic [rrif_pkg::MEAN_W-1:0] loc_q, glob_q;

    assign peak_stall = (state_reg != S_IDLE);
    assign peak_acc   = peak_valid && !peak_stall;
    assign out_free   = !out_valid_reg || !feat_stall;
    assign emit       = (state_reg == S_DIV) && loc_done && glob_done && out_free;
    assign div_start  = (state_reg == S_PUSH);

    // gap to the previous peak, wrapping difference saturated to 16 bits
    always_comb
    begin
        diff = peak.peak_pos - prev_pos_reg;
        gap  = (diff > POS_W'(rrif_pkg::IVL_MAX)) ? rrif_pkg::IVL_MAX : diff[IVL_W-1:0];
    end

    // window push arithmetic
    always_comb
    begin
        win_full = (fill_reg == FILL_W'(LOCAL_WINDOW));
        wsum_new = wsum_reg - (win_full ? WSUM_W'(ring_rdata) : '0) + WSUM_W'(rec_pre_reg);
        fill_new = win_full ? fill_reg : fill_reg + 1'b1;
        gsum_add = {1'b0, gsum_reg} + (GSUM_W + 1)'(rec_pre_reg);
        loc_num  = LNUM_W'(wsum_new) << FRAC_BITS;
        loc_den  = CNT_W'(fill_new);
        // second beat of a stream: the global mean is beat 0's own interval
        if (count_reg == CNT_W'(1))
        begin
            glob_num = GNUM_W'(rec_pre_reg) << FRAC_BITS;
            glob_den = CNT_W'(1);
        end
        else
        begin
            glob_num = GNUM_W'(gsum_reg) << FRAC_BITS;
            glob_den = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (peak_acc && (count_reg != '0))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (emit)
                begin
                    state_next = (fin_reg && !rec_last_reg) ? S_READ : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_pos_reg  <= '0;
            pending_reg   <= '0;
            wsum_reg      <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            gsum_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rec_last_reg  <= 1'b0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!feat_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (peak_acc)
                    begin
                        if (count_reg == '0)
                        begin
                            // first peak of a stream; a lone final peak leaves all clear
                            if (!peak.final_peak)
                            begin
                                prev_pos_reg <= peak.peak_pos;
                                count_reg    <= CNT_W'(1);
                            end
                        end
                        else
                        begin
                            fin_reg      <= peak.final_peak;
                            rec_last_reg <= 1'b0;
                        end
                    end
                end
                S_READ:
                begin
                end
                S_PUSH:
                begin
                    wsum_reg <= wsum_new;
                    fill_reg <= fill_new;
                    head_reg <= (head_reg == HEAD_W'(LOCAL_WINDOW - 1)) ? '0 : head_reg + 1'b1;
                    if (!rec_last_reg)
                    begin
                        gsum_reg     <= gsum_add[GSUM_W] ? rrif_pkg::GSUM_MAX
                                                         : gsum_add[GSUM_W-1:0];
                        pending_reg  <= rec_post_reg;
                        prev_pos_reg <= pos_reg;
                        if (count_reg != rrif_pkg::CNT_MAX)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                S_DIV:
                begin
                    if (emit)
                    begin
                        if (fin_reg && !rec_last_reg)
                        begin
                            rec_last_reg <= 1'b1;
                        end
                        else if (fin_reg)
                        begin
                            prev_pos_reg <= '0;
                            pending_reg  <= '0;
                            wsum_reg     <= '0;
                            fill_reg     <= '0;
                            head_reg     <= '0;
                            gsum_reg     <= '0;
                            count_reg    <= '0;
                            fin_reg      <= 1'b0;
                            rec_last_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (peak_acc && (count_reg != '0))
        begin
            pos_reg      <= peak.peak_pos;
            rec_idx_reg  <= count_reg - 1'b1;
            rec_pre_reg  <= (count_reg == CNT_W'(1)) ? gap : pending_reg;
            rec_post_reg <= gap;
        end
        else if (emit && fin_reg && !rec_last_reg)
        begin
            // closing beat copies the gap that ends it
            rec_idx_reg <= count_reg - 1'b1;
            rec_pre_reg <= rec_post_reg;
        end

        if (emit)
        begin
            out_reg.beat_index    <= rec_idx_reg;
            out_reg.pre_interval  <= rec_pre_reg;
            out_reg.post_interval <= rec_post_reg;
            out_reg.local_mean    <= loc_q;
            out_reg.global_mean   <= glob_q;
            out_reg.last_beat     <= rec_last_reg;
        end
    end

    rrif_ram #(
        .WIDTH (IVL_W),
        .DEPTH (LOCAL_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == S_PUSH),
        .waddr (head_reg),
        .wdata (rec_pre_reg),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    rrif_div #(
        .NUM_W (LNUM_W)
    ) u_loc_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (loc_num),
        .den   (loc_den),
        .done  (loc_done),
        .quot  (loc_q)
    );

    rrif_div #(
        .NUM_W (GNUM_W)
    ) u_glob_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (glob_num),
        .den   (glob_den),
        .done  (glob_done),
        .quot  (glob_q)
    );

    assign feat_valid = out_valid_reg;
    assign feat       = out_reg;

    // window never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LOCAL_WINDOW))
        else $error("window fill over depth");

    // a record is only built for a stream that has seen a peak
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (count_reg != '0))
        else $error("record work with empty stream");

    // leaving the divide state means both means are ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && state_next != S_DIV) |-> (loc_done && glob_done))
        else $error("record left before divide finished");

    // the closing record of a stream is never beat 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (feat_valid && feat.last_beat) |-> (feat.beat_index != '0))
        else $error("last beat record with index zero");

endmodule

[test/tb_rr_interval_features_top.sv]
// Self-checking testbench for the RR-interval feature extractor top level.
module tb_rr_interval_features_top;

    localparam int LOCAL_WIN = 10;
    localparam int FRAC = 8;

    // Stream shapes for the random part: rhythm-like gaps, gaps around the
    // 16-bit ceiling, and arbitrary 32-bit steps (wrap and non-increasing).
    typedef enum int {GAP_RHYTHM, GAP_WIDE, GAP_ANY} gap_kind_e;

    // Receiver back-pressure patterns; one is picked per stretch of cycles.
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_COMB} stall_mode_e;

    // Holds the expected feature records and a shadow of the extractor state.
    class feat_scoreboard;
        rrif_pkg::feat_t expected_feats[$];
        logic [31:0] last_pos;
        logic [15:0] open_pre;
        logic [15:0] win_ring[LOCAL_WIN];
        logic [19:0] win_sum;
        int unsigned win_fill;
        int unsigned win_head;
        logic [39:0] pre_total;
        logic [23:0] beats_seen;
        int          mismatches;
        int          records_checked;
        int          peaks_taken;
        int          streams_closed;

        function new();
            clear_stream();
            mismatches = 0;
            records_checked = 0;
            peaks_taken = 0;
            streams_closed = 0;
        endfunction

        function void clear_stream();
            last_pos = '0;
            open_pre = '0;
            for (int i = 0; i < LOCAL_WIN; i++)
                win_ring[i] = '0;
            win_sum = '0;
            win_fill = 0;
            win_head = 0;
            pre_total = '0;
            beats_seen = '0;
        endfunction

        function void window_add(logic [15:0] v);
            if (win_fill < LOCAL_WIN)
                win_fill++;
            else
                win_sum -= win_ring[win_head];
            win_ring[win_head] = v;
            win_sum += v;
            win_head = (win_head + 1) % LOCAL_WIN;
        endfunction

        // Unsigned fixed-point mean, truncated, clamped to the mean width.
        function logic [23:0] q_mean(logic [63:0] sum, logic [23:0] count);
            logic [63:0] q;
            if (count == 0)
                return '0;
            q = (sum << FRAC) / count;
            if (q > rrif_pkg::MEAN_MAX)
                q = rrif_pkg::MEAN_MAX;
            return q[23:0];
        endfunction

        function int pending();
            return expected_feats.size();
        endfunction

        // Called once per accepted peak beat; queues the records it causes.
        function void note_peak(rrif_pkg::peak_t p);
            logic [31:0] diff;
            logic [15:0] gap;
            logic [15:0] pre_k;
            logic [40:0] grown;
            rrif_pkg::feat_t r;
            peaks_taken++;
            if (beats_seen == 0)
            begin
                last_pos = p.peak_pos;
                beats_seen = 1;
                if (p.final_peak)
                    clear_stream();
                return;
            end
            diff = p.peak_pos - last_pos;
            gap = (diff > 32'(rrif_pkg::IVL_MAX)) ? rrif_pkg::IVL_MAX : diff[15:0];
            // beat 0 borrows the gap that follows it
            pre_k = (beats_seen == 1) ? gap : open_pre;
            window_add(pre_k);
            r.beat_index = beats_seen - 24'd1;
            r.pre_interval = pre_k;
            r.post_interval = gap;
            r.local_mean = q_mean(64'(win_sum), 24'(win_fill));
            r.global_mean = (beats_seen == 1) ? q_mean(64'(pre_k), 24'd1)
                                              : q_mean(64'(pre_total), beats_seen - 24'd1);
            r.last_beat = 1'b0;
            expected_feats.insert(expected_feats.size(), r);
            grown = {1'b0, pre_total} + 41'(pre_k);
            pre_total = (grown > 41'(rrif_pkg::GSUM_MAX)) ? rrif_pkg::GSUM_MAX : grown[39:0];
            open_pre = gap;
            last_pos = p.peak_pos;
            if (beats_seen < rrif_pkg::CNT_MAX)
                beats_seen++;
            if (!p.final_peak)
                return;
            // closing peak: its own record reuses the gap that ends it
            window_add(gap);
            r.beat_index = beats_seen - 24'd1;
            r.pre_interval = gap;
            r.post_interval = gap;
            r.local_mean = q_mean(64'(win_sum), 24'(win_fill));
            r.global_mean = q_mean(64'(pre_total), beats_seen - 24'd1);
            r.last_beat = 1'b1;
            expected_feats.insert(expected_feats.size(), r);
            clear_stream();
            streams_closed++;
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void cmp_field(string nm, logic [39:0] want, logic [39:0] got);
            if (got !== want)
                note_mismatch($sformatf("record %0d %s expected %0h got %0h",
                                        records_checked, nm, want, got));
        endfunction

        // Called once per accepted feature beat.
        function void check_feat(rrif_pkg::feat_t got);
            rrif_pkg::feat_t want;
            if (expected_feats.size() == 0)
            begin
                note_mismatch($sformatf("record with none expected: idx %0h pre %0h last %0b",
                                        got.beat_index, got.pre_interval, got.last_beat));
                return;
            end
            want = expected_feats.pop_front();
            cmp_field("beat_index", want.beat_index, got.beat_index);
            cmp_field("pre_interval", want.pre_interval, got.pre_interval);
            cmp_field("post_interval", want.post_interval, got.post_interval);
            cmp_field("local_mean", want.local_mean, got.local_mean);
            cmp_field("global_mean", want.global_mean, got.global_mean);
            cmp_field("last_beat", want.last_beat, got.last_beat);
            records_checked++;
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            peak_valid;
    logic            peak_stall;
    rrif_pkg::peak_t peak;
    logic            feat_valid;
    logic            feat_stall;
    rrif_pkg::feat_t feat;

    feat_scoreboard sb;
    int burst_left;

    rr_interval_features_top #(
        .LOCAL_WINDOW (LOCAL_WIN),
        .FRAC_BITS    (FRAC)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .peak_valid (peak_valid),
        .peak_stall (peak_stall),
        .peak       (peak),
        .feat_valid (feat_valid),
        .feat_stall (feat_stall),
        .feat       (feat)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run with heavy stalls.
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Sender gap: valid low, payload free to change.
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            peak_valid = 1'b0;
            peak = {$urandom, 1'($urandom)};
        end
    endtask

    // Offer one peak beat and hold it until taken. Bursts of random length
    // with random gaps, so input gaps land on every phase of the divider.
    task automatic offer_peak(input logic [31:0] pos, input logic fin);
        rrif_pkg::peak_t p;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 70));
        end
        burst_left--;
        p.peak_pos = pos;
        p.final_peak = fin;
        @(negedge clk);
        peak_valid = 1'b1;
        peak = p;
        do
            @(posedge clk);
        while (peak_stall);
        sb.note_peak(p);
    endtask

    function automatic logic [31:0] next_gap(gap_kind_e k);
        case (k)
            GAP_RHYTHM: return $urandom_range(150, 3000);
            GAP_WIDE:   return $urandom_range(0, 140000);
            default:    return $urandom;
        endcase
    endfunction

    // One stream of n peaks; the last one carries the final flag.
    task automatic send_stream(input logic [31:0] start, input int n, input gap_kind_e k);
        logic [31:0] pos;
        pos = start;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                pos = pos + next_gap(k);
            offer_peak(pos, i == n - 1);
        end
    endtask

    // Receiver: stall pattern per stretch, plus one long hold-off once the
    // run is under way so the output register fills and the input stalls.
    initial
    begin
        stall_mode_e mode;
        int          mode_left;
        int          hold_left;
        int          cyc;
        bit          held;
        feat_stall = 1'b0;
        mode = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        cyc = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (!held && sb.peaks_taken >= 200)
            begin
                held = 1'b1;
                hold_left = 400;
            end
            if (mode_left == 0)
            begin
                mode = stall_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                feat_stall = 1'b1;
            end
            else
            begin
                case (mode)
                    RX_FREE:  feat_stall = 1'b0;
                    RX_LIGHT: feat_stall = ($urandom_range(0, 3) == 0);
                    RX_HEAVY: feat_stall = ($urandom_range(0, 3) != 0);
                    default:  feat_stall = (cyc % 3 == 0);
                endcase
            end
        end
    end

    // Output monitor: a feature beat moves on valid with no stall.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && feat_valid && !feat_stall)
                sb.check_feat(feat);
        end
    end

    initial
    begin
        int        len;
        int        r;
        gap_kind_e k;
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        peak_valid = 1'b0;
        peak = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // single-peak stream: no record, state returns to reset
        offer_peak(32'h0000_0000, 1'b1);
        // two-peak stream at the top of the position range
        offer_peak(32'hFFFF_FF00, 1'b0);
        offer_peak(32'hFFFF_FFFF, 1'b1);
        // position counter wrapping through zero
        offer_peak(32'hFFFF_FFF0, 1'b0);
        offer_peak(32'h0000_0010, 1'b1);
        // gap at the ceiling, one past it, zero gap, backward step
        offer_peak(32'd1000, 1'b0);
        offer_peak(32'd1000 + 32'd65535, 1'b0);
        offer_peak(32'd1000 + 32'd131071, 1'b0);
        offer_peak(32'd1000 + 32'd131071, 1'b0);
        offer_peak(32'd1000 + 32'd131070, 1'b0);
        offer_peak(32'd1000 + 32'd131071, 1'b1);
        // longer than the local window so the ring wraps
        for (int i = 0; i < 12; i++)
            offer_peak(32'h8000_0000 + 32'(i * (i * 37 + 1)), i == 11);

        // random streams, mostly well formed with rhythm-like gaps
        while (sb.peaks_taken < 550)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                len = 1;
            else if (r < 78)
                len = $urandom_range(2, 15);
            else
                len = $urandom_range(16, 40);
            r = $urandom_range(0, 99);
            k = (r < 70) ? GAP_RHYTHM : (r < 90) ? GAP_WIDE : GAP_ANY;
            send_stream($urandom, len, k);
        end
        idle_cycles(1);

        // drain, then give a stray record time to show up
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("Covered %0d peaks in %0d closed streams (wrap, saturation, long hold-off);",
                 sb.peaks_taken, sb.streams_closed);
        $display("%0d feature records checked, %0d mismatches, %0d still outstanding",
                 sb.records_checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
